>>> sv/oal_pkg.sv
package oal_pkg;

  // List geometry. The list holds at most DEPTH words of VALUE_W bits.
  localparam int unsigned DEPTH   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } oal_kind_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_BAD_POS   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_EMPTY     = 3'd4
  } oal_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_TEST,
    S_INS_MOVE,
    S_DEL_READ,
    S_DEL_CAP,
    S_DEL_TEST,
    S_DEL_MOVE,
    S_SRCH_TEST,
    S_SRCH_CMP,
    S_RESP
  } oal_state_e;

  typedef enum logic [1:0] {
    PTR_COUNT,
    PTR_POS,
    PTR_ZERO
  } oal_ptr_src_e;

  typedef enum logic {
    ADDR_PTR,
    ADDR_PTR_M1
  } oal_addr_e;

  typedef enum logic {
    WDATA_WORD,
    WDATA_SHIFT
  } oal_wdata_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         latch;
    logic         ptr_ld;
    oal_ptr_src_e ptr_src;
    logic         ptr_inc;
    logic         ptr_dec;
    oal_addr_e    raddr_sel;
    logic         wr_en;
    oal_addr_e    waddr_sel;
    oal_wdata_e   wdata_sel;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         cap_removed;
    logic         set_found;
    logic         stat_we;
    oal_status_e  stat_code;
  } oal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    oal_kind_e kind;
    logic      full;
    logic      empty;
    logic      pos_gt_cnt;
    logic      pos_ge_cnt;
    logic      ptr_eq_pos;
    logic      ptr_lt_cnt;
    logic      match;
  } oal_stat_t;

endpackage

>>> sv/ordered_array_list_unit.sv
// Channel    Direction  Handshake            Payload ports
// request    in         start, busy          kind_i, position_i, value_i
// result     out        done_o (one cycle)   status_o, found_index_o, removed_value_o,
//                                            entry_count_o, is_empty_o, is_full_o
//
// A request is taken at a rising edge where start is high and busy is low. The block
// serves one request at a time. A rejected request or the unused kind goes from
// dispatch straight to the result strobe; an insert, delete or search first walks
// the list through the single list RAM, where each entry moved or compared takes a
// read and then a write or compare. Reset clears the entry count and the controller;
// the RAM is not cleared, since only entries below the count are ever read. The result
// receiver cannot stall the block.
module ordered_array_list_unit
  import oal_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic [5:0]          position_i,
  input  logic [31:0]         value_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [4:0]          found_index_o,
  output logic [31:0]         removed_value_o,
  output logic [5:0]          entry_count_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  // The controller steers every datapath step through one command bundle and
  // makes its decisions from start and the status bundle that comes back.
  oal_cmd_t  cmd;
  oal_stat_t stat;

  oal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // The datapath holds the list RAM, the entry count, the walking pointer and
  // the result fields, which stay stable while the result strobe is high.
  oal_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .is_full_o       (is_full_o)
  );

endmodule

>>> sv/oal_ram.sv
module oal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/oal_dp.sv
module oal_dp
  import oal_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oal_cmd_t            cmd_i,
  output oal_stat_t           stat_o,
  input  logic [1:0]          kind_i,
  input  logic [5:0]          position_i,
  input  logic [VALUE_W-1:0]  value_i,
  output logic [2:0]          status_o,
  output logic [ADDR_W-1:0]   found_index_o,
  output logic [VALUE_W-1:0]  removed_value_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  oal_kind_e          kind_q;
  logic [5:0]         pos_q;
  logic [VALUE_W-1:0] word_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d, ptr_m1;
  oal_status_e        status_q;
  logic [ADDR_W-1:0]  found_q;
  logic [VALUE_W-1:0] removed_q;

  logic [ADDR_W-1:0]  raddr, waddr;
  logic [VALUE_W-1:0] wdata, rdata;

  assign ptr_m1 = ptr_q - CNT_W'(1);

  // Request fields are held for the whole operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= oal_kind_e'(kind_i);
      pos_q  <= position_i;
      word_q <= value_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_ld) begin
      case (cmd_i.ptr_src)
        PTR_COUNT: ptr_d = count_q;
        PTR_POS:   ptr_d = pos_q;
        default:   ptr_d = '0;
      endcase
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CNT_W'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  // Result fields of the request in progress.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      status_q  <= STAT_OK;
      found_q   <= '0;
      removed_q <= '0;
    end else begin
      if (cmd_i.stat_we) begin
        status_q <= cmd_i.stat_code;
      end
      if (cmd_i.set_found) begin
        found_q <= ptr_q[ADDR_W-1:0];
      end
      if (cmd_i.cap_removed) begin
        removed_q <= rdata;
      end
    end
  end

  assign raddr = (cmd_i.raddr_sel == ADDR_PTR_M1) ? ptr_m1[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
  assign waddr = (cmd_i.waddr_sel == ADDR_PTR_M1) ? ptr_m1[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
  assign wdata = (cmd_i.wdata_sel == WDATA_SHIFT) ? rdata : word_q;

  oal_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.full       = (count_q == CNT_W'(DEPTH));
    stat_o.empty      = (count_q == '0);
    stat_o.pos_gt_cnt = ({1'b0, pos_q} > 7'(count_q));
    stat_o.pos_ge_cnt = ({1'b0, pos_q} >= 7'(count_q));
    stat_o.ptr_eq_pos = (7'(ptr_q) == {1'b0, pos_q});
    stat_o.ptr_lt_cnt = (ptr_q < count_q);
    stat_o.match      = (rdata == word_q);
  end

  assign status_o        = status_q;
  assign found_index_o   = found_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = count_q;
  assign is_empty_o      = (count_q == '0);
  assign is_full_o       = (count_q == CNT_W'(DEPTH));

  // The list never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // A growing list gains exactly one entry.
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not add one entry");

endmodule

>>> sv/oal_ctrl.sv
module oal_ctrl
  import oal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  input  oal_stat_t stat_i,
  output oal_cmd_t  cmd_o
);

  oal_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != S_IDLE);
    done_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (stat_i.kind)
          KIND_INSERT: begin
            if (stat_i.full) begin
              cmd_o.stat_we   = 1'b1;
              cmd_o.stat_code = STAT_FULL;
              state_d         = S_RESP;
            end else if (stat_i.pos_gt_cnt) begin
              cmd_o.stat_we   = 1'b1;
              cmd_o.stat_code = STAT_BAD_POS;
              state_d         = S_RESP;
            end else begin
              cmd_o.ptr_ld  = 1'b1;
              cmd_o.ptr_src = PTR_COUNT;
              state_d       = S_INS_TEST;
            end
          end
          KIND_DELETE: begin
            if (stat_i.empty) begin
              cmd_o.stat_we   = 1'b1;
              cmd_o.stat_code = STAT_EMPTY;
              state_d         = S_RESP;
            end else if (stat_i.pos_ge_cnt) begin
              cmd_o.stat_we   = 1'b1;
              cmd_o.stat_code = STAT_BAD_POS;
              state_d         = S_RESP;
            end else begin
              cmd_o.ptr_ld  = 1'b1;
              cmd_o.ptr_src = PTR_POS;
              state_d       = S_DEL_READ;
            end
          end
          KIND_SEARCH: begin
            cmd_o.ptr_ld  = 1'b1;
            cmd_o.ptr_src = PTR_ZERO;
            state_d       = S_SRCH_TEST;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Walk down from the tail, moving each entry up by one slot.
      S_INS_TEST: begin
        if (stat_i.ptr_eq_pos) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.waddr_sel = ADDR_PTR;
          cmd_o.wdata_sel = WDATA_WORD;
          cmd_o.cnt_inc   = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.raddr_sel = ADDR_PTR_M1;
          state_d         = S_INS_MOVE;
        end
      end

      S_INS_MOVE: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.waddr_sel = ADDR_PTR;
        cmd_o.wdata_sel = WDATA_SHIFT;
        cmd_o.ptr_dec   = 1'b1;
        state_d         = S_INS_TEST;
      end

      S_DEL_READ: begin
        cmd_o.raddr_sel = ADDR_PTR;
        state_d         = S_DEL_CAP;
      end

      S_DEL_CAP: begin
        cmd_o.cap_removed = 1'b1;
        cmd_o.ptr_inc     = 1'b1;
        state_d           = S_DEL_TEST;
      end

      // Walk up from the hole, moving each entry down by one slot.
      S_DEL_TEST: begin
        if (stat_i.ptr_lt_cnt) begin
          cmd_o.raddr_sel = ADDR_PTR;
          state_d         = S_DEL_MOVE;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end
      end

      S_DEL_MOVE: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.waddr_sel = ADDR_PTR_M1;
        cmd_o.wdata_sel = WDATA_SHIFT;
        cmd_o.ptr_inc   = 1'b1;
        state_d         = S_DEL_TEST;
      end

      S_SRCH_TEST: begin
        if (stat_i.ptr_lt_cnt) begin
          cmd_o.raddr_sel = ADDR_PTR;
          state_d         = S_SRCH_CMP;
        end else begin
          cmd_o.stat_we   = 1'b1;
          cmd_o.stat_code = STAT_NOT_FOUND;
          state_d         = S_RESP;
        end
      end

      S_SRCH_CMP: begin
        if (stat_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_SRCH_TEST;
        end
      end

      S_RESP: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Each result strobe closes the request and frees the block.
  a_resp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result");

  // The list only grows when there is room and only shrinks when it holds something.
  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cnt_inc |-> !stat_i.full) and (cmd_o.cnt_dec |-> !stat_i.empty))
    else $error("entry count changed past a limit");

  // An accepted request is dispatched in the following cycle.
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == S_DISPATCH)
    else $error("accepted request not dispatched");

endmodule

>>> tb/oal_list_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the list unit, keeps its own copy of the list and
// checks every result against the oldest predicted one.
module oal_list_checker
  import oal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] value_i,
  input  logic        done_o,
  input  logic [2:0]  status_o,
  input  logic [4:0]  found_index_o,
  input  logic [31:0] removed_value_o,
  input  logic [5:0]  entry_count_o,
  input  logic        is_empty_o,
  input  logic        is_full_o,
  output int          fail_count,
  output int          pending,
  output int          list_count
);

  typedef struct packed {
    oal_status_e status;
    logic [4:0]  index;
    logic [31:0] removed;
    logic [5:0]  count;
    logic        empty;
    logic        full;
  } list_reply_t;

  logic [31:0]  list_mem [DEPTH];
  int unsigned  list_cnt;
  list_reply_t  predicted_replies [$];

  // Applies one request to the local list and returns the reply it must give.
  function automatic list_reply_t apply_list_op(oal_kind_e op, logic [5:0] pos,
                                                logic [31:0] word);
    list_reply_t r;
    int unsigned i;
    logic        hit;
    r = '0;
    r.status = STAT_OK;
    hit = 1'b0;
    case (op)
      KIND_INSERT: begin
        if (list_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (pos > list_cnt) begin
          r.status = STAT_BAD_POS;
        end else begin
          for (i = list_cnt; i > pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos] = word;
          list_cnt++;
        end
      end
      KIND_DELETE: begin
        if (list_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos >= list_cnt) begin
          r.status = STAT_BAD_POS;
        end else begin
          r.removed = list_mem[pos];
          for (i = pos + 1; i < list_cnt; i++) list_mem[i - 1] = list_mem[i];
          list_cnt--;
        end
      end
      KIND_SEARCH: begin
        r.status = STAT_NOT_FOUND;
        for (i = 0; i < list_cnt; i++) begin
          if (!hit && list_mem[i] == word) begin
            hit = 1'b1;
            r.status = STAT_OK;
            r.index = i[4:0];
          end
        end
      end
      default: ;
    endcase
    r.count = list_cnt[5:0];
    r.empty = (list_cnt == 0);
    r.full  = (list_cnt == DEPTH);
    return r;
  endfunction

  task automatic note_failure(input string what, input list_reply_t want,
                              input list_reply_t got);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected status %0d index %0d removed %h count %0d empty %0b full %0b",
               want.status, want.index, want.removed, want.count, want.empty, want.full);
      $display("  actual   status %0d index %0d removed %h count %0d empty %0b full %0b",
               got.status, got.index, got.removed, got.count, got.empty, got.full);
    end
    fail_count++;
  endtask

  // Results are checked before the request of the same edge is predicted; a
  // result can never belong to a request accepted on that same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t got;
    list_reply_t want;
    if (!rst_ni) begin
      list_cnt = 0;
      predicted_replies.delete();
      fail_count = 0;
      pending = 0;
      list_count = 0;
    end else begin
      if (done_o) begin
        got.status  = oal_status_e'(status_o);
        got.index   = found_index_o;
        got.removed = removed_value_o;
        got.count   = entry_count_o;
        got.empty   = is_empty_o;
        got.full    = is_full_o;
        if (predicted_replies.size() == 0) begin
          note_failure("result with no request outstanding", '0, got);
        end else begin
          want = predicted_replies.pop_front();
          if (got !== want) note_failure("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        predicted_replies.push_back(apply_list_op(oal_kind_e'(kind_i), position_i,
                                                  value_i));
      end
      pending = predicted_replies.size();
      list_count = list_cnt;
    end
  end

endmodule

>>> tb/ordered_array_list_unit_test.sv
`timescale 1ns / 100ps

// Testbench for the positional list unit. The top only produces requests and
// gives the verdict; a checker instance beside the block predicts each result
// and compares it.
//
// A directed opening covers the empty and full list, bad positions on both
// insert and delete, extreme words, duplicate values, search hits and misses
// and the unused kind. The random part then drifts the list between empty and
// full so that both ends are reached many times, with mostly valid positions
// and values drawn from a small pool so that searches hit often.
module ordered_array_list_unit_test;
  import oal_pkg::*;

  // Worst case is a search miss on a full list plus the longest
  // sender gap; the limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 584;
  localparam int SETTLE_CYCLES = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  kind_i = KIND_NONE;
  logic [5:0]  position_i = '0;
  logic [31:0] value_i = '0;
  logic        busy;
  logic        done_o;
  logic [2:0]  status_o;
  logic [4:0]  found_index_o;
  logic [31:0] removed_value_o;
  logic [5:0]  entry_count_o;
  logic        is_empty_o;
  logic        is_full_o;

  int fail_count;
  int pending;
  int list_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  bit growing = 1'b1;

  // Small pool of words so that random searches find duplicates and hits.
  logic [31:0] word_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                 32'h0000_0000, 32'h0000_0019, 32'h0000_0001,
                                 32'h5a5a_a5a5, 32'hdead_beef};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ordered_array_list_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .is_full_o       (is_full_o)
  );

  oal_list_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .is_full_o       (is_full_o),
    .fail_count      (fail_count),
    .pending         (pending),
    .list_count      (list_count)
  );

  // Watchdog: a hung handshake must still end the run with a verdict.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one request. It is entered and left at a falling edge. The
  // sender may first stay idle, at each turn with a chance of send_idle_pct
  // percent; then start is held with the payload until a rising edge finds
  // busy low. Start is never lowered between two back-to-back requests, so
  // each falling edge sees at most one assignment to it.
  task automatic issue_request(input oal_kind_e op, input logic [5:0] pos,
                               input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start      <= 1'b1;
    kind_i     <= op;
    position_i <= pos;
    value_i    <= word;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // One random request. The list drifts toward full or toward empty and
  // turns around at the ends, sometimes only after a rejected request there.
  task automatic random_request();
    int          cnt;
    int          roll;
    oal_kind_e   op;
    logic [5:0]  pos;
    logic [31:0] word;
    cnt = list_count;
    if (cnt == DEPTH && $urandom_range(1) == 1) begin
      growing = 1'b0;
    end else if (cnt == 0 && $urandom_range(1) == 1) begin
      growing = 1'b1;
    end else if ($urandom_range(99) == 0) begin
      growing = !growing;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      op = KIND_NONE;
    end else if (roll < 18) begin
      op = KIND_SEARCH;
    end else if ((roll < 78) == growing) begin
      op = KIND_INSERT;
    end else begin
      op = KIND_DELETE;
    end
    // Mostly legal positions, the rest anywhere in the field.
    if ($urandom_range(99) < 12) begin
      pos = 6'($urandom_range(63));
    end else if (op == KIND_DELETE && cnt > 0) begin
      pos = 6'($urandom_range(cnt - 1));
    end else begin
      pos = 6'($urandom_range(cnt));
    end
    if ($urandom_range(99) < 60) begin
      word = word_pool[$urandom_range(7)];
    end else begin
      word = $urandom();
    end
    issue_request(op, pos, word);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening on an empty list.
    issue_request(KIND_DELETE, 6'd0, 32'h0);             // delete when empty
    issue_request(KIND_SEARCH, 6'd0, 32'h0);             // search on empty list
    issue_request(KIND_NONE, 6'd63, 32'hffff_ffff);      // unused kind
    issue_request(KIND_INSERT, 6'd1, 32'h1);             // insert past count
    issue_request(KIND_INSERT, 6'd63, 32'h1);            // insert far past count
    issue_request(KIND_INSERT, 6'd0, 32'h8000_0000);
    issue_request(KIND_INSERT, 6'd1, 32'h7fff_ffff);
    issue_request(KIND_INSERT, 6'd1, 32'hffff_ffff);
    issue_request(KIND_INSERT, 6'd0, 32'h0000_0000);
    issue_request(KIND_INSERT, 6'd4, 32'hffff_ffff);     // duplicate at the end
    issue_request(KIND_SEARCH, 6'd63, 32'hffff_ffff);    // lowest of two matches
    issue_request(KIND_SEARCH, 6'd0, 32'h8000_0000);
    issue_request(KIND_SEARCH, 6'd0, 32'h7fff_ffff);
    issue_request(KIND_SEARCH, 6'd0, 32'h0000_0019);     // search miss
    issue_request(KIND_DELETE, 6'd5, 32'h0);             // delete at count
    issue_request(KIND_DELETE, 6'd63, 32'h0);            // delete far past end
    issue_request(KIND_DELETE, 6'd1, 32'h0);
    issue_request(KIND_DELETE, 6'd3, 32'h0);             // delete the last entry
    issue_request(KIND_NONE, 6'd21, 32'h1234_5678);

    // Fill the list by appending, ending with a known word at the top index.
    while (list_count < DEPTH - 1) issue_request(KIND_INSERT, 6'(list_count), $urandom());
    issue_request(KIND_INSERT, 6'(DEPTH - 1), 32'h0000_0019);
    issue_request(KIND_SEARCH, 6'd0, 32'h0000_0019);     // hit at the top index
    issue_request(KIND_INSERT, 6'd0, 32'h1);             // insert when full
    issue_request(KIND_INSERT, 6'd63, 32'h1);            // full wins over position
    issue_request(KIND_DELETE, 6'(DEPTH - 1), 32'h0);
    issue_request(KIND_DELETE, 6'd0, 32'h0);

    // Hold the sender until the directed part has fully drained.
    drain_results();

    // Random part in three phases of sender idling: light, heavy, none.
    send_idle_pct = 21;
    repeat (PHASE_ITEMS) random_request();
    drain_results();
    send_idle_pct = 78;
    repeat (PHASE_ITEMS) random_request();
    drain_results();
    send_idle_pct = 0;
    repeat (PHASE_ITEMS) random_request();
    drain_results();

    // Leave time for any stray result to show up before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
